// ===== rtl/core/wcsd_pkg.sv =====
`default_nettype none

package wcsd_pkg;

    localparam int DATA_W = 4;
    localparam int CHIP_W = 4;
    localparam int ACC_W  = 6;

    localparam int CHIP_MAX = 7;
    localparam int CHIP_MIN = -8;

    localparam logic OP_SPREAD   = 1'b0;
    localparam logic OP_DESPREAD = 1'b1;

    localparam logic KIND_CHIP = 1'b0;
    localparam logic KIND_BITS = 1'b1;

    // one token travelling down the row of user cells
    typedef struct packed {
        logic                     valid;
        logic                     op;
        logic                     last;
        logic [DATA_W-1:0]        bits;
        logic signed [CHIP_W-1:0] chip;
        logic [DATA_W-1:0]        dec;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/core/wcsd_head.sv =====
`default_nettype none

module wcsd_head
    import wcsd_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int PW           = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire logic                     i_valid,
    input  wire logic                     i_op,
    input  wire logic [DATA_W-1:0]        i_user_bits,
    input  wire logic signed [CHIP_W-1:0] i_chip_in,
    output logic                          o_stall,
    output t_tok                          o_tok,
    output logic [PW-1:0]                 o_pos
);

    localparam logic [PW-1:0] PosLast = PW'(NUM_CHANNELS - 1);

    logic              r_busy;
    logic [PW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_bits;
    logic [PW-1:0]     r_dpos;
    logic              w_accept;

    assign w_accept = i_valid && !r_busy && i_adv;
    assign o_stall  = r_busy || !i_adv;

    always_comb begin
        o_tok = '0;
        o_pos = '0;
        if (r_busy) begin
            // remaining chips of a spread word
            o_tok.valid = 1'b1;
            o_tok.op    = OP_SPREAD;
            o_tok.last  = (r_cnt == PosLast);
            o_tok.bits  = r_bits;
            o_pos       = r_cnt;
        end else if (i_op == OP_SPREAD) begin
            o_tok.valid = i_valid;
            o_tok.op    = OP_SPREAD;
            o_tok.bits  = i_user_bits;
        end else begin
            o_tok.valid = i_valid;
            o_tok.op    = OP_DESPREAD;
            o_tok.last  = (r_dpos == PosLast);
            o_tok.chip  = i_chip_in;
            o_pos       = r_dpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_bits <= '0;
            r_dpos <= '0;
        end else if (i_adv) begin
            if (r_busy) begin
                r_cnt <= r_cnt + PW'(1);
                if (r_cnt == PosLast) begin
                    r_busy <= 1'b0;
                end
            end else if (w_accept) begin
                if (i_op == OP_SPREAD) begin
                    r_busy <= 1'b1;
                    r_cnt  <= PW'(1);
                    r_bits <= i_user_bits;
                end else if (r_dpos == PosLast) begin
                    r_dpos <= '0;
                end else begin
                    r_dpos <= r_dpos + PW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wcsd_cell.sv =====
`default_nettype none

module wcsd_cell
    import wcsd_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int PW           = 2,
    parameter int SW           = 4,
    parameter int U            = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire t_tok                 i_tok,
    input  wire logic [PW-1:0]        i_pos,
    input  wire logic signed [SW-1:0] i_psum,
    output t_tok                      o_tok,
    output logic [PW-1:0]             o_pos,
    output logic signed [SW-1:0]      o_psum
);

    localparam logic [PW-1:0] UId  = PW'(U);
    localparam int            NegN = -NUM_CHANNELS;

    t_tok                     r_tok;
    logic [PW-1:0]            r_pos;
    logic signed [SW-1:0]     r_psum;
    logic signed [ACC_W-1:0]  r_acc;

    t_tok                     n_tok;
    logic signed [SW-1:0]     n_psum;
    logic                     w_code;
    logic                     w_lvl;
    logic [DATA_W-1:0]        w_mask;
    logic signed [ACC_W:0]    w_chip;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W-1:0]  w_sat;
    logic                     w_neg;

    // code entry is -1 when popcount(u and c) is odd
    assign w_code = ^(UId & i_pos);

    generate
        if (U < DATA_W) begin : g_bit
            assign w_lvl  = i_tok.bits[U];
            assign w_mask = DATA_W'(1) << U;
        end else begin : g_nobit
            assign w_lvl  = 1'b0;
            assign w_mask = '0;
        end
    endgenerate

    assign w_chip = {{(ACC_W + 1 - CHIP_W){i_tok.chip[CHIP_W-1]}}, i_tok.chip};
    assign w_sum  = w_code ? ({r_acc[ACC_W-1], r_acc} - w_chip)
                           : ({r_acc[ACC_W-1], r_acc} + w_chip);

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    // truncated quotient is negative only when the sum reaches -n
    assign w_neg = (int'(w_sat) <= NegN);

    always_comb begin
        n_tok  = i_tok;
        n_psum = i_psum;
        if (i_tok.op == OP_SPREAD) begin
            n_psum = (w_lvl ^ w_code) ? i_psum - SW'(1) : i_psum + SW'(1);
        end else if (i_tok.last) begin
            n_tok.dec = w_neg ? (i_tok.dec | w_mask) : (i_tok.dec & ~w_mask);
        end
    end

    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos  <= i_pos;
            r_psum <= n_psum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_adv && i_tok.valid && i_tok.op == OP_DESPREAD) begin
            r_acc <= i_tok.last ? '0 : w_sat;
        end
    end

    assign o_pos  = r_pos;
    assign o_psum = r_psum;

endmodule

`default_nettype wire

// ===== rtl/core/walsh_cdma_spread_despread.sv =====
// walsh-hadamard cdma spreader and despreader for NUM_CHANNELS users
//
// input channel: i_valid / o_stall with i_op, i_user_bits, i_chip_in.
//   a spread word (op 0) yields NUM_CHANNELS chip words on the output, the
//   last one flagged; o_stall is high until its last chip is issued.
//   a despread word (op 1) carries one received chip, taken each cycle
//   o_stall is low; every NUM_CHANNELS-th chip yields a decoded word.
// output channel: o_valid / i_stall with o_kind, o_chip_out,
//   o_decoded_bits, o_last, held in an output register.
// each word walks a row of NUM_CHANNELS user cells, one per cycle
//   unless the row holds, each cell holding one user's correlator;
//   the last cell feeds the output register.
// when the receiver stalls a full output register, the whole row holds
//   and o_stall rises; nothing is lost.
// reset clears the chip position, all correlators and every valid flag.
`default_nettype none

module walsh_cdma_spread_despread
    import wcsd_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_op,
    input  wire logic [DATA_W-1:0]        i_user_bits,
    input  wire logic signed [CHIP_W-1:0] i_chip_in,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_kind,
    output logic signed [CHIP_W-1:0]      o_chip_out,
    output logic [DATA_W-1:0]             o_decoded_bits,
    output logic                          o_last
);

    localparam int PW = $clog2(NUM_CHANNELS);
    localparam int SW = $clog2(NUM_CHANNELS) + 2;

    t_tok                 w_tok  [NUM_CHANNELS+1];
    logic [PW-1:0]        w_pos  [NUM_CHANNELS+1];
    logic signed [SW-1:0] w_psum [NUM_CHANNELS+1];
    logic                 w_adv;

    logic                       r_out_valid;
    logic                       r_kind;
    logic signed [CHIP_W-1:0]   r_chip;
    logic [DATA_W-1:0]          r_dec;
    logic                       r_last;
    logic signed [CHIP_W-1:0]   n_chip;
    t_tok                       w_tail;

    assign w_adv = !r_out_valid || !i_stall;

    wcsd_head #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PW           (PW)
    ) u_head (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_user_bits (i_user_bits),
        .i_chip_in   (i_chip_in),
        .o_stall     (o_stall),
        .o_tok       (w_tok[0]),
        .o_pos       (w_pos[0])
    );

    assign w_psum[0] = '0;

    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
            wcsd_cell #(
                .NUM_CHANNELS (NUM_CHANNELS),
                .PW           (PW),
                .SW           (SW),
                .U            (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_tok   (w_tok[g]),
                .i_pos   (w_pos[g]),
                .i_psum  (w_psum[g]),
                .o_tok   (w_tok[g+1]),
                .o_pos   (w_pos[g+1]),
                .o_psum  (w_psum[g+1])
            );
        end
    endgenerate

    assign w_tail = w_tok[NUM_CHANNELS];

    // chip sum clamps to the output range
    always_comb begin
        if (int'(w_psum[NUM_CHANNELS]) > CHIP_MAX) begin
            n_chip = CHIP_W'(CHIP_MAX);
        end else if (int'(w_psum[NUM_CHANNELS]) < CHIP_MIN) begin
            n_chip = CHIP_W'(CHIP_MIN);
        end else begin
            n_chip = CHIP_W'(w_psum[NUM_CHANNELS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tail.valid && (w_tail.op == OP_SPREAD || w_tail.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last <= w_tail.last;
            if (w_tail.op == OP_SPREAD) begin
                r_kind <= KIND_CHIP;
                r_chip <= n_chip;
                r_dec  <= '0;
            end else begin
                r_kind <= KIND_BITS;
                r_chip <= '0;
                r_dec  <= w_tail.dec;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_chip_out     = r_chip;
    assign o_decoded_bits = r_dec;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/wcsd_checker.sv =====
`default_nettype none

module wcsd_checker
    import wcsd_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_stall,
    input wire logic                     i_op,
    input wire logic [DATA_W-1:0]        i_user_bits,
    input wire logic signed [CHIP_W-1:0] i_chip_in,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic                     o_kind,
    input wire logic signed [CHIP_W-1:0] o_chip_out,
    input wire logic [DATA_W-1:0]        o_decoded_bits,
    input wire logic                     o_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_chip_out)
            && $stable(o_decoded_bits) && $stable(o_last)))
        else $error("output word changed under stall");

    // a blocked output backs up into the input
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output blocked");

    // the two result kinds keep their unused fields clear
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == KIND_CHIP && o_decoded_bits == '0)
            || (o_kind == KIND_BITS && o_chip_out == '0 && o_last)))
        else $error("result fields inconsistent with kind");

    // chips of one spread word follow each other without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_kind == KIND_CHIP && !o_last)
            |=> (o_valid && o_kind == KIND_CHIP))
        else $error("gap inside a spread burst");

endmodule

bind walsh_cdma_spread_despread wcsd_checker u_wcsd_checker (.*);

`default_nettype wire
